/* sv/surface_normal_rgba_encoder_top_defines.svh */
// Assertion macros for the surface normal encoder.
// No dependencies; the including module must have clk and rst_n in scope.
`ifndef SURFACE_NORMAL_RGBA_ENCODER_TOP_DEFINES_SVH
`define SURFACE_NORMAL_RGBA_ENCODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define SNRE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("snre assertion failed");
// Check a property on every clock edge, reset included
`define SNRE_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("snre assertion failed");
`else
`define SNRE_ASSERT(lbl, prop)
`define SNRE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* sv/snre_pkg.sv */
// Shared constants, types and functions of the surface normal encoder.
// No dependencies.
`timescale 1ns / 1ps
package snre_pkg;

    localparam int COORD_BITS = 12;
    localparam int GRAD_BITS  = 32;
    localparam int SUM_BITS   = 2 * GRAD_BITS;
    localparam int ROOT_BITS  = GRAD_BITS;
    localparam int Q_BITS     = 17;
    localparam int T_BITS     = Q_BITS + 1;
    localparam int SQ_STAGES  = ROOT_BITS;
    localparam int DIV_STAGES = Q_BITS;
    localparam int LATENCY    = 3 + SQ_STAGES + 1 + DIV_STAGES + 1;

    localparam logic [Q_BITS-1:0] Q_ONE     = 17'h10000;
    localparam logic [31:0]       TOP_WORD  = 32'hffff7f7f;
    localparam logic [7:0]        ALPHA     = 8'hff;
    localparam logic [7:0]        ZERO_BYTE = 8'd127;

    // Item data carried down the pipeline next to the arithmetic
    typedef struct packed {
        logic [2:0][GRAD_BITS-1:0] mag;
        logic [2:0]                neg;
        logic [COORD_BITS-1:0]     px;
        logic [COORD_BITS-1:0]     py;
        logic                      top;
    } side_t;

    // Map a signed Q1.16 ratio (magnitude and sign) to a channel byte
    function automatic logic [7:0] chan_byte(input logic [Q_BITS-1:0] q, input logic neg);
        logic [T_BITS-1:0] t;
        logic [25:0]       p;
        t = neg ? ({1'b0, Q_ONE} - {1'b0, q}) : ({1'b0, Q_ONE} + {1'b0, q});
        p = {t, 8'b0} - {8'b0, t};
        return p[24:17];
    endfunction

endpackage

/* sv/surface_normal_rgba_encoder_top.sv */
// Throughput: one item per cycle; busy stays low, since the receiver cannot stall.
// Depth is set by the bit-per-stage square root (32 stages) and divider (17 stages).
// Reset (rst_n, asynchronous, active low) clears all stage valid bits.
// Top level: squares, integer square root, Q1.16 ratios and byte packing.
// Depends on snre_pkg and surface_normal_rgba_encoder_top_defines.svh.
`timescale 1ns / 1ps
`include "surface_normal_rgba_encoder_top_defines.svh"
module surface_normal_rgba_encoder_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [31:0]              grad_x,
    input  logic signed [31:0]              grad_y,
    input  logic signed [31:0]              grad_z,
    input  logic [snre_pkg::COORD_BITS-1:0] pixel_x,
    input  logic [snre_pkg::COORD_BITS-1:0] pixel_y,
    input  logic                            at_top,
    output logic                            done,
    output logic [31:0]                     normal_word,
    output logic [snre_pkg::COORD_BITS-1:0] out_x,
    output logic [snre_pkg::COORD_BITS-1:0] out_y
);

    localparam int GB  = snre_pkg::GRAD_BITS;
    localparam int SB  = snre_pkg::SUM_BITS;
    localparam int RB  = snre_pkg::ROOT_BITS;
    localparam int QB  = snre_pkg::Q_BITS;
    localparam int NS  = snre_pkg::SQ_STAGES;
    localparam int ND  = snre_pkg::DIV_STAGES;
    localparam int LAT = snre_pkg::LATENCY;

    logic accept;
    logic [2:0][GB-1:0] raw;
    snre_pkg::side_t side_a_next;

    logic va_reg, vb_reg;
    snre_pkg::side_t side_a_reg, side_b_reg;
    logic [2:0][SB-1:0] sq_reg;

    logic            sv_reg   [0:NS];
    logic [SB-1:0]   sd_reg   [0:NS];
    logic [RB-1:0]   sr_reg   [0:NS];
    snre_pkg::side_t sside_reg[0:NS];
    logic [SB-1:0]   sd_next  [0:NS-1];
    logic [RB-1:0]   sr_next  [0:NS-1];

    logic                dv_reg   [0:ND];
    logic [RB-1:0]       dlen_reg [0:ND];
    logic [2:0][RB-1:0]  drem_reg [0:ND];
    logic [2:0][QB-1:0]  dq_reg   [0:ND];
    snre_pkg::side_t     dside_reg[0:ND];
    logic [2:0][RB-1:0]  drem_next[0:ND-1];
    logic [2:0][QB-1:0]  dq_next  [0:ND-1];

    logic [31:0] word_next;
    logic [7:0]  bx, by, bz;

    // The pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start;

    // Take magnitudes and signs of the gradient
    always_comb
    begin
        raw[0] = grad_x;
        raw[1] = grad_y;
        raw[2] = grad_z;
        for (int c = 0; c < 3; c++)
        begin
            side_a_next.neg[c] = raw[c][GB-1];
            side_a_next.mag[c] = raw[c][GB-1] ? (~raw[c] + 1'b1) : raw[c];
        end
        side_a_next.px  = pixel_x;
        side_a_next.py  = pixel_y;
        side_a_next.top = at_top;
    end

    // Square-root step: set one root bit per stage
    always_comb
    begin
        logic [SB+1:0] trial;
        for (int k = 0; k < NS; k++)
        begin
            trial = ({{(SB+2-RB){1'b0}}, sr_reg[k]} << (RB - k))
                  | ({{(SB+1){1'b0}}, 1'b1} << (2 * (RB - 1 - k)));
            if ({2'b00, sd_reg[k]} >= trial)
            begin
                sd_next[k] = sd_reg[k] - trial[SB-1:0];
                sr_next[k] = sr_reg[k] | (RB'(1) << (RB - 1 - k));
            end
            else
            begin
                sd_next[k] = sd_reg[k];
                sr_next[k] = sr_reg[k];
            end
        end
    end

    // Divide step: one quotient bit per stage for each channel
    always_comb
    begin
        logic [RB:0] shifted;
        logic        nb;
        for (int k = 0; k < ND; k++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                nb      = (k == 0) ? dside_reg[k].mag[c][0] : 1'b0;
                shifted = {drem_reg[k][c], nb};
                if (shifted >= {1'b0, dlen_reg[k]})
                begin
                    drem_next[k][c] = RB'(shifted - {1'b0, dlen_reg[k]});
                    dq_next[k][c]   = dq_reg[k][c] | (QB'(1) << (QB - 1 - k));
                end
                else
                begin
                    drem_next[k][c] = shifted[RB-1:0];
                    dq_next[k][c]   = dq_reg[k][c];
                end
            end
        end
    end

    // Pack the channel bytes; a zero length gives the zero word, and the top flag gives TOP_WORD
    always_comb
    begin
        bx = snre_pkg::chan_byte(dq_reg[ND][0], dside_reg[ND].neg[0]);
        by = snre_pkg::chan_byte(dq_reg[ND][1], dside_reg[ND].neg[1]);
        bz = snre_pkg::chan_byte(dq_reg[ND][2], dside_reg[ND].neg[2]);
        if (dlen_reg[ND] == '0)
        begin
            word_next = {snre_pkg::ALPHA, snre_pkg::ZERO_BYTE, snre_pkg::ZERO_BYTE,
                         snre_pkg::ZERO_BYTE};
        end
        else
        begin
            word_next = {snre_pkg::ALPHA, bz, by, bx};
        end
        if (dside_reg[ND].top)
        begin
            word_next = snre_pkg::TOP_WORD;
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            for (int k = 0; k <= NS; k++)
            begin
                sv_reg[k] <= 1'b0;
            end
            for (int k = 0; k <= ND; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
            done <= 1'b0;
        end
        else
        begin
            va_reg    <= accept;
            vb_reg    <= va_reg;
            sv_reg[0] <= vb_reg;
            for (int k = 0; k < NS; k++)
            begin
                sv_reg[k+1] <= sv_reg[k];
            end
            dv_reg[0] <= sv_reg[NS];
            for (int k = 0; k < ND; k++)
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
            done <= dv_reg[ND];
        end
    end

    // Advance the data of every stage
    always_ff @(posedge clk)
    begin
        side_a_reg <= side_a_next;
        for (int c = 0; c < 3; c++)
        begin
            sq_reg[c] <= SB'(side_a_reg.mag[c]) * SB'(side_a_reg.mag[c]);
        end
        side_b_reg <= side_a_reg;

        sd_reg[0]    <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        sr_reg[0]    <= '0;
        sside_reg[0] <= side_b_reg;
        for (int k = 0; k < NS; k++)
        begin
            sd_reg[k+1]    <= sd_next[k];
            sr_reg[k+1]    <= sr_next[k];
            sside_reg[k+1] <= sside_reg[k];
        end

        dlen_reg[0]  <= sr_reg[NS];
        dside_reg[0] <= sside_reg[NS];
        dq_reg[0]    <= '0;
        for (int c = 0; c < 3; c++)
        begin
            drem_reg[0][c] <= sside_reg[NS].mag[c] >> 1;
        end
        for (int k = 0; k < ND; k++)
        begin
            dlen_reg[k+1]  <= dlen_reg[k];
            dside_reg[k+1] <= dside_reg[k];
            drem_reg[k+1]  <= drem_next[k];
            dq_reg[k+1]    <= dq_next[k];
        end

        normal_word <= word_next;
        out_x       <= dside_reg[ND].px;
        out_y       <= dside_reg[ND].py;
    end

    `SNRE_ASSERT(a_done_follows_start, done |-> $past(start, LAT))
    `SNRE_ASSERT(a_coord_x, done |-> out_x == $past(pixel_x, LAT))
    `SNRE_ASSERT(a_top_word, (done && $past(at_top, LAT)) |-> normal_word == snre_pkg::TOP_WORD)
    `SNRE_ASSERT(a_alpha, done |-> normal_word[31:24] == snre_pkg::ALPHA)
    `SNRE_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !done)

endmodule

/* verif/surface_normal_rgba_encoder_top_tb.sv */
// Testbench for the surface normal encoder: directed table, then random gradients.
// Depends on snre_pkg and surface_normal_rgba_encoder_top; results checked in order.
`timescale 1ns / 1ps
module surface_normal_rgba_encoder_top_tb;

    localparam int  N_RANDOM    = 1250;
    localparam int  N_DIRECT    = 16;
    localparam int  QUEUE_DEPTH = 256;
    localparam logic [31:0] NO_WORD = 32'h0;

    typedef struct {
        logic [31:0]                     gx;
        logic [31:0]                     gy;
        logic [31:0]                     gz;
        logic [snre_pkg::COORD_BITS-1:0] px;
        logic [snre_pkg::COORD_BITS-1:0] py;
        logic                            top;
        logic [31:0]                     word;   // NO_WORD: take it from the predictor
    } stim_t;

    typedef struct {
        logic [31:0]                     word;
        logic [snre_pkg::COORD_BITS-1:0] x;
        logic [snre_pkg::COORD_BITS-1:0] y;
    } pixel_t;

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic signed [31:0]              grad_x;
    logic signed [31:0]              grad_y;
    logic signed [31:0]              grad_z;
    logic [snre_pkg::COORD_BITS-1:0] pixel_x;
    logic [snre_pkg::COORD_BITS-1:0] pixel_y;
    logic                            at_top;
    logic                            done;
    logic [31:0]                     normal_word;
    logic [snre_pkg::COORD_BITS-1:0] out_x;
    logic [snre_pkg::COORD_BITS-1:0] out_y;

    pixel_t pending_pixels[QUEUE_DEPTH];
    int     n_queued;
    int     n_retired;
    int     n_errors;
    int     n_checked;
    int     idle_pct;

    surface_normal_rgba_encoder_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .grad_x(grad_x), .grad_y(grad_y), .grad_z(grad_z),
        .pixel_x(pixel_x), .pixel_y(pixel_y), .at_top(at_top),
        .done(done), .normal_word(normal_word), .out_x(out_x), .out_y(out_y)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Floor square root, one result bit per pass
    function automatic logic [63:0] floor_root(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem  = n;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Clamped Q1.16 ratio of one component, mapped to its byte
    function automatic logic [7:0] ratio_byte(input logic [31:0] c, input logic [63:0] len);
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] t;
        mag = c[31] ? {32'b0, (~c) + 32'd1} : {32'b0, c};
        q   = (mag << 16) / len;
        if (q > 64'd65536)
            q = 64'd65536;
        t = c[31] ? 64'd65536 - q : 64'd65536 + q;
        return 8'((64'd255 * t) >> 17);
    endfunction

    function automatic logic [31:0] encode_normal(input stim_t s);
        logic [63:0] mx;
        logic [63:0] my;
        logic [63:0] mz;
        logic [63:0] len;
        mx  = s.gx[31] ? {32'b0, (~s.gx) + 32'd1} : {32'b0, s.gx};
        my  = s.gy[31] ? {32'b0, (~s.gy) + 32'd1} : {32'b0, s.gy};
        mz  = s.gz[31] ? {32'b0, (~s.gz) + 32'd1} : {32'b0, s.gz};
        len = floor_root(mx * mx + my * my + mz * mz);
        if (s.top)
            return snre_pkg::TOP_WORD;
        if (len == 0)
            return {snre_pkg::ALPHA, snre_pkg::ZERO_BYTE, snre_pkg::ZERO_BYTE,
                    snre_pkg::ZERO_BYTE};
        return {snre_pkg::ALPHA, ratio_byte(s.gz, len), ratio_byte(s.gy, len),
                ratio_byte(s.gx, len)};
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // Expectations waiting for their pixel
    function automatic int pending_count();
        return n_queued - n_retired;
    endfunction

    task automatic queue_pixel(input pixel_t p);
        pending_pixels[n_queued % QUEUE_DEPTH] = p;
        n_queued++;
    endtask

    // Check every strobed pixel against the oldest expectation
    always @(posedge clk)
    begin
        pixel_t exp_p;
        if (rst_n && done)
        begin
            if (pending_count() == 0)
                report_mismatch("unexpected pixel", normal_word, NO_WORD);
            else
            begin
                exp_p = pending_pixels[n_retired % QUEUE_DEPTH];
                n_retired++;
                n_checked++;
                if (normal_word !== exp_p.word)
                    report_mismatch("normal_word", normal_word, exp_p.word);
                if (out_x !== exp_p.x)
                    report_mismatch("out_x", 32'(out_x), 32'(exp_p.x));
                if (out_y !== exp_p.y)
                    report_mismatch("out_y", 32'(out_y), 32'(exp_p.y));
            end
        end
    end

    // Present one item and hold it until the transfer
    task automatic send_item(input stim_t s);
        pixel_t p;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        grad_x  <= s.gx;
        grad_y  <= s.gy;
        grad_z  <= s.gz;
        pixel_x <= s.px;
        pixel_y <= s.py;
        at_top  <= s.top;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        p.word = (s.word != NO_WORD) ? s.word : encode_normal(s);
        p.x    = s.px;
        p.y    = s.py;
        queue_pixel(p);
    endtask

    function automatic logic [31:0] rand_grad();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(200)) - 100);
            2: return $urandom_range(1) ? 32'h80000000 : 32'h7fffffff;
            3: return 32'($signed($urandom_range(65535)) - 32768);
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    stim_t directed_rows[N_DIRECT];

    initial
    begin
        stim_t       s;
        logic [31:0] rnd;
        directed_rows = '{
            // zero vector
            '{0, 0, 0, 0, 0, 0, 32'hff7f7f7f},
            // at top, the first with coordinates at their extremes
            '{32'h12345678, 32'h80000000, 5, 12'hfff, 12'hfff, 1, snre_pkg::TOP_WORD},
            '{0, 0, 0, 12'h0a5, 12'hf5a, 1, snre_pkg::TOP_WORD},
            // unit axes
            '{1, 0, 0, 1, 2, 0, 32'hff7f7fff},
            '{32'hffffffff, 0, 0, 3, 4, 0, 32'hff7f7f00},
            '{0, 1, 0, 5, 6, 0, 32'hff7fff7f},
            '{0, 0, 32'hffffffff, 7, 8, 0, 32'hff007f7f},
            // extreme components, handled through the unsigned magnitude
            '{32'h80000000, 32'h80000000, 32'h80000000, 12'h800, 12'h001, 0, NO_WORD},
            '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 12'h7ff, 12'h800, 0, NO_WORD},
            '{32'h80000000, 0, 0, 9, 9, 0, 32'hff7f7f00},
            '{0, 32'h7fffffff, 0, 10, 10, 0, 32'hff7fff7f},
            // floored length drives the ratio up to one
            '{1, 1, 0, 11, 11, 0, NO_WORD},
            '{1, 1, 1, 12, 12, 0, NO_WORD},
            '{32'hffffffff, 1, 32'hffffffff, 13, 13, 0, NO_WORD},
            '{3, 32'hfffffffc, 12, 14, 15, 0, NO_WORD},
            '{32'h7fffffff, 32'h80000000, 1, 12'h555, 12'haaa, 0, NO_WORD}
        };
        rst_n     = 1'b0;
        start     = 1'b0;
        grad_x    = 0;
        grad_y    = 0;
        grad_z    = 0;
        pixel_x   = 0;
        pixel_y   = 0;
        at_top    = 1'b0;
        n_queued  = 0;
        n_retired = 0;
        n_errors  = 0;
        n_checked = 0;
        idle_pct  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table back to back
        foreach (directed_rows[i])
            send_item(directed_rows[i]);

        // Random gradients in phases of sender idling; two of the phases have no gaps
        for (int i = 0; i < N_RANDOM; i++)
        begin
            case (i * 4 / N_RANDOM)
                0: idle_pct = 0;
                1: idle_pct = 88;
                2: idle_pct = 0;
                default: idle_pct = 14;
            endcase
            s.gx   = rand_grad();
            s.gy   = rand_grad();
            s.gz   = rand_grad();
            rnd    = $urandom;
            s.px   = rnd[snre_pkg::COORD_BITS-1:0];
            rnd    = $urandom;
            s.py   = rnd[snre_pkg::COORD_BITS-1:0];
            s.top  = ($urandom_range(15) == 0);
            s.word = NO_WORD;
            send_item(s);
        end
        start <= 1'b0;

        // Drain the pipeline
        while (pending_count() != 0)
            @(posedge clk);
        repeat (snre_pkg::LATENCY + 10) @(posedge clk);

        $display("covered %0d directed and %0d random gradients, %0d pixels checked",
                 N_DIRECT, N_RANDOM, n_checked);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Guard against a hung pipeline
    initial
    begin
        #5ms;
        $display("timeout with %0d pixels outstanding", pending_count());
        $display("== FAIL ==");
        $finish;
    end

endmodule
